@@ rtl/pcxrle_pkg.sv @@
// Shared types and constants for the PCX run-length decoder with histogram.
// No dependencies; imported by pcxrle_hist and pcx_rle_decoder_with_histogram.
`timescale 1ns / 1ps

package pcxrle_pkg;

  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned COUNT_W       = 25;
  localparam int unsigned RUN_W         = 6;
  localparam int unsigned NUM_COLORS    = 256;
  localparam int unsigned MAX_PIXELS_DEF = 16777216;

  localparam logic [COLOR_W-1:0] PREFIX_MASK = 8'hc0;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  // Input transaction kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Result kinds
  localparam logic RK_PIXEL = 1'b0;
  localparam logic RK_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COLOR_W-1:0] data_byte;
    logic [COLOR_W-1:0] color_index;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [COLOR_W-1:0] pixel_value;
    logic               last_pixel;
    logic [COUNT_W-1:0] color_count;
  } out_t;

  // Histogram memory access request
  typedef struct packed {
    logic               rd_en;
    logic [COLOR_W-1:0] rd_addr;
    logic               wr_en;
    logic [COLOR_W-1:0] wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               clear;
  } hist_req_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

endpackage

@@ rtl/pcxrle_hist.sv @@
// Per-color histogram store: 256 x 25-bit synchronous memory, registered read.
// Valid bits make unwritten entries read as zero. Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_hist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcxrle_pkg::hist_req_t        req,
  output logic [pcxrle_pkg::COUNT_W-1:0] rd_data
);
  import pcxrle_pkg::*;

  logic [COUNT_W-1:0]    mem [NUM_COLORS];
  logic [NUM_COLORS-1:0] valid_r;
  logic [COUNT_W-1:0]    rd_q_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

@@ rtl/pcx_rle_decoder_with_histogram.sv @@
// Top level of the PCX run-length decoder with per-color histogram.
// Depends on pcxrle_pkg and pcxrle_hist.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_payload): one transaction per
//   encoded byte, histogram query or restart. in_stall is high while a
//   transaction is being worked on.
//   Output channel (out_valid / out_stall / out_payload): one transaction per
//   decoded pixel or histogram answer, from a single output register.
//   Config port (cfg_wr_en / cfg_wr_data): pixel_total, written while idle.
// Sequencing (states per transaction)
//   Run prefix, restart, unknown kind, zero-length run or byte past the
//   image end: taken in ST_IDLE alone. Query: ST_IDLE, then ST_LOOKUP, which
//   registers the answer. Literal byte: ST_IDLE, ST_LOOKUP, ST_EMIT. Run
//   value: ST_IDLE, ST_LOOKUP, then ST_EMIT once per pixel, clipped at the
//   total; pixels come one per cycle while no result waits on out_stall.
// Reset
//   Clears the histogram (valid bits), pixel count and pending run prefix;
//   pixel_total returns to 1.
// Stall
//   While a result waits on out_stall the emit loop holds and input stays stalled; a new
//   input transaction may still be accepted while the last result waits.
module pcx_rle_decoder_with_histogram #(
  parameter int unsigned MAX_PIXELS = pcxrle_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pcxrle_pkg::in_t                in_payload,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pcxrle_pkg::out_t               out_payload,
  input  logic                           cfg_wr_en,
  input  logic [pcxrle_pkg::COUNT_W-1:0] cfg_wr_data
);
  import pcxrle_pkg::*;

  localparam logic [COUNT_W-1:0] MaxTotal = COUNT_W'(MAX_PIXELS);

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] total_r;
  logic [COUNT_W-1:0] total_eff;
  logic [COUNT_W-1:0] pix_r, pix_nxt;
  logic               await_r, await_nxt;
  logic [RUN_W-1:0]   run_len_r, run_len_nxt;
  logic [RUN_W-1:0]   rem_r, rem_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               query_r, query_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] pix_inc;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_payload_r, out_payload_nxt;
  logic               out_free;
  logic               in_accept;
  logic               complete;
  logic               emit_go;
  hist_req_t          hreq;
  logic [COUNT_W-1:0] hist_rd;

  pcxrle_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_rd)
  );

  // Out-of-range totals: zero acts as one, large values clip to MaxTotal.
  always_comb begin
    total_eff = total_r;
    if (total_r == '0) begin
      total_eff = COUNT_W'(1);
    end else if (total_r > MaxTotal) begin
      total_eff = MaxTotal;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign complete  = (pix_r >= total_eff);
  assign cnt_inc   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
  assign pix_inc   = pix_r + COUNT_W'(1);
  assign emit_go   = (state_r == ST_EMIT) && out_free;

  always_comb begin
    state_nxt       = state_r;
    pix_nxt         = pix_r;
    await_nxt       = await_r;
    run_len_nxt     = run_len_r;
    rem_nxt         = rem_r;
    color_nxt       = color_r;
    query_nxt       = query_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_payload_nxt = out_payload_r;

    hreq         = '0;
    hreq.rd_addr = (in_payload.kind == KIND_QUERY) ? in_payload.color_index
                                                    : in_payload.data_byte;
    hreq.wr_addr = color_r;
    hreq.wr_data = cnt_inc;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // Issue the histogram read for whatever entry this transaction may touch.
          hreq.rd_en = 1'b1;
          color_nxt  = hreq.rd_addr;
          query_nxt  = 1'b0;
          case (in_payload.kind)
            KIND_DATA: begin
              if (!complete) begin
                if (await_r) begin
                  await_nxt   = 1'b0;
                  run_len_nxt = '0;
                  rem_nxt     = run_len_r;
                  if (run_len_r != '0) begin
                    state_nxt = ST_LOOKUP;
                  end
                end else if ((in_payload.data_byte & PREFIX_MASK) == PREFIX_MASK) begin
                  await_nxt   = 1'b1;
                  run_len_nxt = in_payload.data_byte[RUN_W-1:0];
                end else begin
                  rem_nxt   = RUN_W'(1);
                  state_nxt = ST_LOOKUP;
                end
              end
            end
            KIND_QUERY: begin
              query_nxt = 1'b1;
              state_nxt = ST_LOOKUP;
            end
            KIND_RESTART: begin
              hreq.clear  = 1'b1;
              await_nxt   = 1'b0;
              run_len_nxt = '0;
              pix_nxt     = '0;
            end
            default: begin
              // Unknown kind: drop.
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (query_r) begin
          // Hold the answer until the output register frees up.
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_payload_nxt.result_kind = RK_COUNT;
            out_payload_nxt.pixel_value = '0;
            out_payload_nxt.last_pixel  = 1'b0;
            out_payload_nxt.color_count = hist_rd;
            state_nxt                   = ST_IDLE;
          end
        end else begin
          cnt_nxt   = hist_rd;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          // Emit one pixel and write the bumped count back.
          hreq.wr_en                  = 1'b1;
          cnt_nxt                     = cnt_inc;
          pix_nxt                     = pix_inc;
          rem_nxt                     = rem_r - RUN_W'(1);
          out_valid_nxt               = 1'b1;
          out_payload_nxt.result_kind = RK_PIXEL;
          out_payload_nxt.pixel_value = color_r;
          out_payload_nxt.last_pixel  = (pix_inc == total_eff);
          out_payload_nxt.color_count = '0;
          // End the run at its last pixel, or clip it at the image total.
          if (rem_r == RUN_W'(1) || pix_inc == total_eff) begin
            rem_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= COUNT_W'(1);
      pix_r       <= '0;
      await_r     <= 1'b0;
      run_len_r   <= '0;
      rem_r       <= '0;
      query_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_r       <= pix_nxt;
      await_r     <= await_nxt;
      run_len_r   <= run_len_nxt;
      rem_r       <= rem_nxt;
      query_r     <= query_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r       <= color_nxt;
    cnt_r         <= cnt_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  // Each emitted pixel advances the pixel count by exactly one.
  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> pix_r == $past(pix_inc))
    else $error("pixel count did not advance on emit");

  // The emit loop never runs with an exhausted run.
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> rem_r != '0)
    else $error("emit state with zero remaining pixels");

  // A new read never overlaps a histogram write-back (interlock by stall).
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !hreq.wr_en)
    else $error("histogram read accepted during write-back");

  // A last-pixel mark always coincides with reaching the image total.
  a_last_at_total: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && out_payload_nxt.last_pixel) |=> pix_r == total_eff)
    else $error("last pixel marked before the image total");

endmodule

@@ dv/pcx_rle_decoder_with_histogram_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the PCX run-length decoder with histogram: follows the
// image state from observed config and input transactions and checks every
// result transaction in order. Depends on pcxrle_pkg.

module pcx_rle_decoder_with_histogram_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  pcxrle_pkg::in_t                in_payload,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  pcxrle_pkg::out_t               out_payload,
  input  logic                           cfg_wr_en,
  input  logic [pcxrle_pkg::COUNT_W-1:0] cfg_wr_data,
  output int unsigned                    error_count,
  output int unsigned                    pending_results,
  output int unsigned                    pixels_checked,
  output int unsigned                    answers_checked
);
  import pcxrle_pkg::*;

  localparam int unsigned PIXEL_CAP = MAX_PIXELS_DEF;

  logic               run_pending;
  logic [RUN_W-1:0]   run_count;
  int unsigned        emitted;
  int unsigned        total_setting;
  logic [COUNT_W-1:0] color_hist [NUM_COLORS];
  out_t               expected_results [$];

  // Pixel total as the block applies it: zero acts as one, clip at the cap.
  function automatic int unsigned image_budget();
    if (total_setting == 0) return 1;
    if (total_setting > PIXEL_CAP) return PIXEL_CAP;
    return total_setting;
  endfunction

  function automatic bit field_ok(input string name, input longint unsigned want,
                                  input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_image();
    run_pending = 1'b0;
    run_count   = '0;
    emitted     = 0;
    foreach (color_hist[c]) color_hist[c] = '0;
  endtask

  // Emit up to count pixels of one color, clipped to what the image has left.
  task automatic emit_run(input logic [COLOR_W-1:0] color, input int unsigned count);
    int unsigned budget;
    out_t        pix;
    budget = image_budget();
    for (int unsigned i = 0; i < count && emitted < budget; i++) begin
      emitted++;
      if (color_hist[color] != COUNT_MAX) color_hist[color]++;
      pix             = '0;
      pix.result_kind = RK_PIXEL;
      pix.pixel_value = color;
      pix.last_pixel  = (emitted == budget);
      expected_results.push_back(pix);
    end
  endtask

  task automatic decode_transaction(input in_t item);
    out_t             answer;
    logic [RUN_W-1:0] len;
    case (item.kind)
      KIND_QUERY: begin
        answer             = '0;
        answer.result_kind = RK_COUNT;
        answer.color_count = color_hist[item.color_index];
        expected_results.push_back(answer);
      end
      KIND_RESTART: clear_image();
      KIND_DATA: begin
        if (emitted < image_budget()) begin
          if (run_pending) begin
            len         = run_count;
            run_pending = 1'b0;
            run_count   = '0;
            emit_run(item.data_byte, 32'(len));
          end else if ((item.data_byte & PREFIX_MASK) == PREFIX_MASK) begin
            run_pending = 1'b1;
            run_count   = item.data_byte[RUN_W-1:0];
          end else begin
            emit_run(item.data_byte, 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Check results before predicting: a transaction accepted at this edge
  // cannot have produced a result at the same edge.
  always @(posedge clk) begin : track
    out_t want;
    bit   ok;
    if (!rst_n) begin
      clear_image();
      total_setting = 1;
      expected_results.delete();
      error_count     = 0;
      pixels_checked  = 0;
      answers_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d pixel 'h%0h count %0d",
                 out_payload.result_kind, out_payload.pixel_value,
                 out_payload.color_count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          ok  = field_ok("result_kind", 64'(want.result_kind), 64'(out_payload.result_kind));
          ok &= field_ok("pixel_value", 64'(want.pixel_value), 64'(out_payload.pixel_value));
          ok &= field_ok("last_pixel", 64'(want.last_pixel), 64'(out_payload.last_pixel));
          ok &= field_ok("color_count", 64'(want.color_count), 64'(out_payload.color_count));
          if (!ok) error_count++;
          if (want.result_kind == RK_PIXEL) pixels_checked++;
          else answers_checked++;
        end
      end
      if (cfg_wr_en) total_setting = 32'(cfg_wr_data);
      if (in_valid && !in_stall) decode_transaction(in_payload);
    end
    pending_results = expected_results.size();
  end

endmodule

@@ dv/pcx_rle_decoder_with_histogram_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the PCX run-length decoder with histogram: drives
// stimulus and config, and gives the verdict. Depends on pcxrle_pkg, the
// block and pcx_rle_decoder_with_histogram_scoreboard.

module pcx_rle_decoder_with_histogram_test;
  import pcxrle_pkg::*;

  // The kind code the block must ignore; the package leaves it unnamed.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Longest stretch the block can still be busy after its last result:
  // a 63-pixel run plus the histogram lookup, with some margin.
  localparam int unsigned SETTLE_CYCLES = 70;

  localparam logic [COUNT_W-1:0] TOTAL_ALL_ONES = {COUNT_W{1'b1}};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_payload;
  logic               out_valid;
  logic               out_stall;
  out_t               out_payload;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  int unsigned error_count;
  int unsigned pending_results;
  int unsigned pixels_checked;
  int unsigned answers_checked;

  // Sender pacing: bursts of back-to-back transactions, random gaps between.
  int unsigned burst_left    = 0;
  int unsigned max_gap       = 0;
  int unsigned items_sent    = 0;
  int unsigned settings_used = 0;
  logic [7:0]  recent_color  = 8'h00;

  // Receiver stall pattern state.
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;

  always #6 clk = ~clk;

  pcx_rle_decoder_with_histogram uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pcx_rle_decoder_with_histogram_scoreboard pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload     (out_payload),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .error_count     (error_count),
    .pending_results (pending_results),
    .pixels_checked  (pixels_checked),
    .answers_checked (answers_checked)
  );

  // Receiver: switch among a few stall patterns every so often -- never
  // stall, stall now and then, stall mostly, and a regular on/off beat from span bit 2.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_span = $urandom_range(200, 20);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(3, 0) == 0);
      2:       out_stall <= ($urandom_range(3, 0) != 0);
      default: out_stall <= stall_span[2];
    endcase
  end

  // Present one transaction and hold it until accepted. A gap, if any, is
  // taken before raising valid so valid never drops and rises in one step.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data_byte,
                           input logic [7:0] color_index);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(max_gap, 0);
      burst_left = $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid               = 1'b1;
    in_payload.kind        = kind;
    in_payload.data_byte   = data_byte;
    in_payload.color_index = color_index;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  // in case it is still busy with a transaction that yields nothing.
  task automatic drain_and_settle();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(input logic [COUNT_W-1:0] value);
    drain_and_settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed image data (literals and prefix/value pairs) with
  // queries, restarts, unused kinds and stray bytes mixed in. Fields the
  // block ignores for a kind carry random values. hold_at >= 0 makes the
  // sender wait once, when that many items have gone, until every expected
  // result has come.
  task automatic send_random_items(input int unsigned count, input int unsigned restart_pct,
                                   input int hold_at);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [7:0]  color;
    sent = 0;
    while (sent < count) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        in_valid = 1'b0;
        while (pending_results != 0) @(negedge clk);
        hold_at = -1;
      end
      pick = $urandom_range(99, 0);
      if (pick < restart_pct) begin
        send_item(KIND_RESTART, 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < restart_pct + 10) begin
        // Favor colors that were just decoded so counts come back nonzero.
        color = ($urandom_range(1, 0) == 1) ? recent_color : 8'($urandom);
        send_item(KIND_QUERY, 8'($urandom), color);
        sent++;
      end else if (pick < restart_pct + 13) begin
        send_item(KIND_UNUSED, 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < restart_pct + 17) begin
        send_item(KIND_DATA, 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < restart_pct + 50) begin
        run_len      = ($urandom_range(4, 0) == 0) ? $urandom_range(63, 0)
                                                   : $urandom_range(8, 0);
        recent_color = 8'($urandom);
        send_item(KIND_DATA, PREFIX_MASK | 8'(run_len), 8'($urandom));
        send_item(KIND_DATA, recent_color, 8'($urandom));
        sent += 2;
      end else begin
        recent_color = 8'($urandom_range(8'hbf, 0));
        send_item(KIND_DATA, recent_color, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] total;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_payload  = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed image of 20 pixels: literal extremes, a zero-length run, a
    // run whose value byte looks like a prefix, a 63-run clipped at the
    // total, bytes past the end, queries, an unused kind and a restart.
    write_total(COUNT_W'(20));
    max_gap = 3;
    send_item(KIND_RESTART, 8'h00, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'hff);
    send_item(KIND_DATA, 8'hbf, 8'h00);
    send_item(KIND_DATA, 8'hc0, 8'h00);
    send_item(KIND_DATA, 8'h55, 8'h00);
    send_item(KIND_DATA, 8'hc3, 8'h00);
    send_item(KIND_DATA, 8'hff, 8'h00);
    send_item(KIND_DATA, 8'hff, 8'h00);
    send_item(KIND_DATA, 8'hc1, 8'h00);
    send_item(KIND_DATA, 8'h12, 8'h00);
    send_item(KIND_QUERY, 8'h00, 8'hff);
    send_item(KIND_QUERY, 8'hff, 8'hc1);
    send_item(KIND_QUERY, 8'h00, 8'h00);
    send_item(KIND_QUERY, 8'h00, 8'hbf);
    send_item(KIND_QUERY, 8'h00, 8'h55);
    send_item(KIND_UNUSED, 8'hff, 8'hff);
    send_item(KIND_RESTART, 8'hff, 8'hff);
    send_item(KIND_QUERY, 8'h00, 8'hc1);

    // Random phases, each under its own pixel total. Phase 5 skips the
    // restart so that a lowered total lands on an image already past it.
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       total = '0;
        1:       total = COUNT_W'(1);
        2:       total = COUNT_W'($urandom_range(40, 2));
        3:       total = TOTAL_ALL_ONES;
        4:       total = COUNT_W'(MAX_PIXELS_DEF);
        5:       total = COUNT_W'($urandom_range(20, 2));
        6:       total = COUNT_W'($urandom_range(400, 41));
        7:       total = COUNT_W'(7);
        default: total = COUNT_W'($urandom_range(1000, 100));
      endcase
      write_total(total);
      max_gap = (p % 3 == 0) ? 0 : $urandom_range(8, 1);
      if (p != 5) send_item(KIND_RESTART, 8'($urandom), 8'($urandom));
      send_random_items(20, (total < 50) ? 15 : 4, (p == 6) ? 12 : -1);
    end

    drain_and_settle();
    $display("Sent %0d transactions under %0d pixel totals, zero and above-cap included.",
             items_sent, settings_used);
    $display("Checked %0d decoded pixels and %0d histogram answers.",
             pixels_checked, answers_checked);
    if (error_count == 0 && pending_results == 0) begin
      $display("pcx_rle_decoder_with_histogram: match");
    end else begin
      $display("pcx_rle_decoder_with_histogram: mismatch");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results);
    $display("pcx_rle_decoder_with_histogram: mismatch");
    $finish;
  end

endmodule
